>>> design/euler_angles_to_rotation_matrix_defines.svh
// assertion macros for the euler angle to rotation matrix block
// used by the checker file only
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
// implication checked on every clock edge outside reset
`define EAR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define EAR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> design/ear_pkg.sv
// shared types, constants and helpers for the euler angle to rotation matrix block
// no dependencies
package ear_pkg;
   localparam int CORDIC_STEPS = 28;
   localparam int ONE_Q30 = 1 << 30;
   localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

   localparam logic [4:0] SEQ_X = 5'd0;
   localparam logic [4:0] SEQ_Y = 5'd1;
   localparam logic [4:0] SEQ_Z = 5'd2;
   localparam logic [4:0] SEQ_XY = 5'd3;
   localparam logic [4:0] SEQ_XZ = 5'd4;
   localparam logic [4:0] SEQ_YX = 5'd5;
   localparam logic [4:0] SEQ_YZ = 5'd6;
   localparam logic [4:0] SEQ_ZX = 5'd7;
   localparam logic [4:0] SEQ_ZY = 5'd8;
   localparam logic [4:0] SEQ_ZYX = 5'd9;
   localparam logic [4:0] SEQ_XYX = 5'd10;
   localparam logic [4:0] SEQ_XYZ = 5'd11;
   localparam logic [4:0] SEQ_XZX = 5'd12;
   localparam logic [4:0] SEQ_XZY = 5'd13;
   localparam logic [4:0] SEQ_YXY = 5'd14;
   localparam logic [4:0] SEQ_YXZ = 5'd15;
   localparam logic [4:0] SEQ_YZX = 5'd16;
   localparam logic [4:0] SEQ_YZY = 5'd17;
   localparam logic [4:0] SEQ_ZXY = 5'd18;
   localparam logic [4:0] SEQ_ZXZ = 5'd19;
   localparam logic [4:0] SEQ_ZYZ = 5'd20;

   // q30 value with room for sums of two products
   typedef logic signed [33:0] q30_type;

   typedef struct packed {
      q30_type s1, c1, s2, c2, s3, c3;
   } trig_type;

   function automatic logic signed [33:0] atan_entry(input int i);
      logic signed [33:0] r;
      case (i)
         0: r = 34'sd536870912;  1: r = 34'sd316933406;
         2: r = 34'sd167458907;  3: r = 34'sd85004756;
         4: r = 34'sd42667331;   5: r = 34'sd21354465;
         6: r = 34'sd10680862;   7: r = 34'sd5340245;
         8: r = 34'sd2670163;    9: r = 34'sd1335087;
         10: r = 34'sd667544;    11: r = 34'sd333772;
         12: r = 34'sd166886;    13: r = 34'sd83443;
         14: r = 34'sd41722;     15: r = 34'sd20861;
         16: r = 34'sd10430;     17: r = 34'sd5215;
         18: r = 34'sd2608;      19: r = 34'sd1304;
         20: r = 34'sd652;       21: r = 34'sd326;
         22: r = 34'sd163;       23: r = 34'sd81;
         24: r = 34'sd41;        25: r = 34'sd20;
         26: r = 34'sd10;        27: r = 34'sd5;
         default: r = '0;
      endcase
      return r;
   endfunction

   // rounded q30 product, floor((a*b + 2^29) / 2^30)
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [67:0] pr;
      pr = a * b + (68'sd1 <<< 29);
      return pr[63:30];
   endfunction
endpackage

>>> design/ear_stream_if.sv
// valid/ready channel carrying a packed payload
// depends on nothing
interface ear_stream_if #(parameter int WIDTH = 8);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> design/ear_cordic.sv
// pipelined cordic sine/cosine for three angles, STAGE_STEPS iterations per stage
// depends on ear_pkg
module ear_cordic #(
   parameter int ANGLE_BITS = 16,
   parameter int STAGE_STEPS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [2:0][ANGLE_BITS-1:0] angle,
   input  logic [4:0] seq_in,
   input  logic valid_in,
   output ear_pkg::trig_type trig,
   output logic [4:0] seq_out,
   output logic valid_out
);
   import ear_pkg::*;
   localparam int NST = CORDIC_STEPS / STAGE_STEPS;

   logic [NST:0] vld_ff;
   logic [NST:0][4:0] seq_ff;
   q30_type x_ff [NST+1][3];
   q30_type y_ff [NST+1][3];
   q30_type z_ff [NST+1][3];
   logic neg_ff [NST+1][3];
   logic [2:0][31:0] ph;

   // entry: phase scaling and half-turn fold
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ph[k] = 32'(angle[k]) << (32 - ANGLE_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seq_ff[0] <= seq_in;
         for (int k = 0; k < 3; k++) begin
            q30_type z0;
            z0 = {{2{ph[k][31]}}, ph[k]};
            x_ff[0][k] <= GAIN_INV;
            y_ff[0][k] <= '0;
            if (z0 > q30_type'(ONE_Q30)) begin
               z_ff[0][k] <= z0 - (q30_type'(ONE_Q30) <<< 1);
               neg_ff[0][k] <= 1'b1;
            end else if (z0 < -q30_type'(ONE_Q30)) begin
               z_ff[0][k] <= z0 + (q30_type'(ONE_Q30) <<< 1);
               neg_ff[0][k] <= 1'b1;
            end else begin
               z_ff[0][k] <= z0;
               neg_ff[0][k] <= 1'b0;
            end
         end
         for (int s = 0; s < NST; s++) begin
            seq_ff[s+1] <= seq_ff[s];
            for (int k = 0; k < 3; k++) begin
               q30_type x, y, z, nx;
               x = x_ff[s][k];
               y = y_ff[s][k];
               z = z_ff[s][k];
               for (int j = 0; j < STAGE_STEPS; j++) begin
                  if (z >= 0) begin
                     nx = x - (y >>> (s * STAGE_STEPS + j));
                     y = y + (x >>> (s * STAGE_STEPS + j));
                     z = z - atan_entry(s * STAGE_STEPS + j);
                  end else begin
                     nx = x + (y >>> (s * STAGE_STEPS + j));
                     y = y - (x >>> (s * STAGE_STEPS + j));
                     z = z + atan_entry(s * STAGE_STEPS + j);
                  end
                  x = nx;
               end
               x_ff[s+1][k] <= x;
               y_ff[s+1][k] <= y;
               z_ff[s+1][k] <= z;
               neg_ff[s+1][k] <= neg_ff[s][k];
            end
         end
      end
   end

   function automatic q30_type fix(input q30_type v, input logic n);
      q30_type r;
      r = n ? -v : v;
      if (r > q30_type'(ONE_Q30)) r = q30_type'(ONE_Q30);
      if (r < -q30_type'(ONE_Q30)) r = -q30_type'(ONE_Q30);
      return r;
   endfunction

   assign trig.s1 = fix(y_ff[NST][0], neg_ff[NST][0]);
   assign trig.c1 = fix(x_ff[NST][0], neg_ff[NST][0]);
   assign trig.s2 = fix(y_ff[NST][1], neg_ff[NST][1]);
   assign trig.c2 = fix(x_ff[NST][1], neg_ff[NST][1]);
   assign trig.s3 = fix(y_ff[NST][2], neg_ff[NST][2]);
   assign trig.c3 = fix(x_ff[NST][2], neg_ff[NST][2]);
   assign seq_out = seq_ff[NST];
   assign valid_out = vld_ff[NST];
endmodule

>>> design/ear_matrix.sv
// product stages and element selection for each rotation sequence
// depends on ear_pkg
module ear_matrix #(
   parameter int FRAC_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  ear_pkg::trig_type trig,
   input  logic [4:0] seq_in,
   input  logic valid_in,
   output logic [8:0][FRAC_BITS+1:0] elem,
   output logic bad,
   output logic valid_out
);
   import ear_pkg::*;
   localparam int SH = 30 - FRAC_BITS;

   // stage a: pair products
   trig_type t_ff;
   q30_type s1s2_ff, s1c2_ff, c1s2_ff, c1c2_ff, s2s3_ff, s2c3_ff, c2s3_ff, c2c3_ff;
   q30_type s1s3_ff, s1c3_ff, c1s3_ff, c1c3_ff;
   logic [4:0] seqa_ff, seqb_ff;
   logic [2:0] vld_ff;
   // stage b: triple products
   trig_type tb_ff;
   q30_type ps1s2, ps1c2, pc1s2, pc1c2, ps2s3, ps2c3, pc2s3, pc2c3;
   q30_type ps1s3, ps1c3, pc1s3, pc1c3;
   q30_type a_ff [12];
   q30_type t_ss_s, t_ss_c, t_cs_s, t_cs_c, t_sc_s, t_sc_c, t_cc_s, t_cc_c;
   q30_type tr_ff [8];
   q30_type e [9];
   logic badc;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff <= trig;
         seqa_ff <= seq_in;
         s1s2_ff <= qmul(trig.s1, trig.s2); s1c2_ff <= qmul(trig.s1, trig.c2);
         c1s2_ff <= qmul(trig.c1, trig.s2); c1c2_ff <= qmul(trig.c1, trig.c2);
         s2s3_ff <= qmul(trig.s2, trig.s3); s2c3_ff <= qmul(trig.s2, trig.c3);
         c2s3_ff <= qmul(trig.c2, trig.s3); c2c3_ff <= qmul(trig.c2, trig.c3);
         s1s3_ff <= qmul(trig.s1, trig.s3); s1c3_ff <= qmul(trig.s1, trig.c3);
         c1s3_ff <= qmul(trig.c1, trig.s3); c1c3_ff <= qmul(trig.c1, trig.c3);
         tb_ff <= t_ff;
         seqb_ff <= seqa_ff;
         a_ff[0] <= s1s2_ff; a_ff[1] <= s1c2_ff; a_ff[2] <= c1s2_ff; a_ff[3] <= c1c2_ff;
         a_ff[4] <= s2s3_ff; a_ff[5] <= s2c3_ff; a_ff[6] <= c2s3_ff; a_ff[7] <= c2c3_ff;
         a_ff[8] <= s1s3_ff; a_ff[9] <= s1c3_ff; a_ff[10] <= c1s3_ff; a_ff[11] <= c1c3_ff;
         // t(x1,x2,x3) = p(p(x1,x2),x3)
         tr_ff[0] <= qmul(s1s2_ff, t_ff.s3); tr_ff[1] <= qmul(s1s2_ff, t_ff.c3);
         tr_ff[2] <= qmul(c1s2_ff, t_ff.s3); tr_ff[3] <= qmul(c1s2_ff, t_ff.c3);
         tr_ff[4] <= qmul(s1c2_ff, t_ff.s3); tr_ff[5] <= qmul(s1c2_ff, t_ff.c3);
         tr_ff[6] <= qmul(c1c2_ff, t_ff.s3); tr_ff[7] <= qmul(c1c2_ff, t_ff.c3);
      end
   end

   assign ps1s2 = a_ff[0]; assign ps1c2 = a_ff[1]; assign pc1s2 = a_ff[2];
   assign pc1c2 = a_ff[3]; assign ps2s3 = a_ff[4]; assign ps2c3 = a_ff[5];
   assign pc2s3 = a_ff[6]; assign pc2c3 = a_ff[7]; assign ps1s3 = a_ff[8];
   assign ps1c3 = a_ff[9]; assign pc1s3 = a_ff[10]; assign pc1c3 = a_ff[11];
   assign t_ss_s = tr_ff[0]; assign t_ss_c = tr_ff[1];
   assign t_cs_s = tr_ff[2]; assign t_cs_c = tr_ff[3];
   assign t_sc_s = tr_ff[4]; assign t_sc_c = tr_ff[5];
   assign t_cc_s = tr_ff[6]; assign t_cc_c = tr_ff[7];

   always_comb begin
      q30_type o, s1, c1, s2, c2;
      o = q30_type'(ONE_Q30);
      s1 = tb_ff.s1; c1 = tb_ff.c1; s2 = tb_ff.s2; c2 = tb_ff.c2;
      badc = 1'b0;
      for (int k = 0; k < 9; k++) e[k] = '0;
      unique case (seqb_ff)
         SEQ_X: begin e[0]=o; e[4]=c1; e[5]=s1; e[7]=-s1; e[8]=c1; end
         SEQ_Y: begin e[0]=c1; e[2]=-s1; e[4]=o; e[6]=s1; e[8]=c1; end
         SEQ_Z: begin e[0]=c1; e[1]=s1; e[3]=-s1; e[4]=c1; e[8]=o; end
         SEQ_XY: begin e[0]=c2; e[1]=ps1s2; e[2]=-pc1s2; e[4]=c1; e[5]=s1;
            e[6]=s2; e[7]=-ps1c2; e[8]=pc1c2; end
         SEQ_XZ: begin e[0]=c2; e[1]=pc1s2; e[2]=ps1s2; e[3]=-s2; e[4]=pc1c2;
            e[5]=ps1c2; e[7]=-s1; e[8]=c1; end
         SEQ_YX: begin e[0]=c1; e[2]=-s1; e[3]=ps1s2; e[4]=c2; e[5]=pc1s2;
            e[6]=ps1c2; e[7]=-s2; e[8]=pc1c2; end
         SEQ_YZ: begin e[0]=pc1c2; e[1]=s2; e[2]=-ps1c2; e[3]=-pc1s2; e[4]=c2;
            e[5]=ps1s2; e[6]=s1; e[8]=c1; end
         SEQ_ZX: begin e[0]=c1; e[1]=s1; e[3]=-ps1c2; e[4]=pc1c2; e[5]=s2;
            e[6]=ps1s2; e[7]=-pc1s2; e[8]=c2; end
         SEQ_ZY: begin e[0]=pc1c2; e[1]=ps1c2; e[2]=-s2; e[3]=-s1; e[4]=c1;
            e[6]=pc1s2; e[7]=ps1s2; e[8]=c2; end
         SEQ_ZYX: begin e[0]=pc1c2; e[1]=ps1c2; e[2]=-s2;
            e[3]=t_cs_s-ps1c3; e[4]=t_ss_s+pc1c3; e[5]=pc2s3;
            e[6]=t_cs_c+ps1s3; e[7]=t_ss_c-pc1s3; e[8]=pc2c3; end
         SEQ_XYX: begin e[0]=c2; e[1]=ps1s2; e[2]=-pc1s2;
            e[3]=ps2s3; e[4]=-t_sc_s+pc1c3; e[5]=t_cc_s+ps1c3;
            e[6]=ps2c3; e[7]=-t_sc_c-pc1s3; e[8]=t_cc_c-ps1s3; end
         SEQ_XYZ: begin e[0]=pc2c3; e[1]=t_ss_c+pc1s3; e[2]=-t_cs_c+ps1s3;
            e[3]=-pc2s3; e[4]=-t_ss_s+pc1c3; e[5]=t_cs_s+ps1c3;
            e[6]=s2; e[7]=-ps1c2; e[8]=pc1c2; end
         SEQ_XZX: begin e[0]=c2; e[1]=pc1s2; e[2]=ps1s2;
            e[3]=-ps2c3; e[4]=t_cc_c-ps1s3; e[5]=t_sc_c+pc1s3;
            e[6]=ps2s3; e[7]=-t_cc_s-ps1c3; e[8]=-t_sc_s+pc1c3; end
         SEQ_XZY: begin e[0]=pc2c3; e[1]=t_cs_c+ps1s3; e[2]=t_ss_c-pc1s3;
            e[3]=-s2; e[4]=pc1c2; e[5]=ps1c2;
            e[6]=pc2s3; e[7]=t_cs_s-ps1c3; e[8]=t_ss_s+pc1c3; end
         SEQ_YXY: begin e[0]=-t_sc_s+pc1c3; e[1]=ps2s3; e[2]=-t_cc_s-ps1c3;
            e[3]=ps1s2; e[4]=c2; e[5]=pc1s2;
            e[6]=t_sc_c+pc1s3; e[7]=-ps2c3; e[8]=t_cc_c-ps1s3; end
         SEQ_YXZ: begin e[0]=pc1c3+t_ss_s; e[1]=pc2s3; e[2]=-ps1c3+t_cs_s;
            e[3]=-pc1s3+t_ss_c; e[4]=pc2c3; e[5]=ps1s3+t_cs_c;
            e[6]=ps1c2; e[7]=-s2; e[8]=pc1c2; end
         SEQ_YZX: begin e[0]=pc1c2; e[1]=s2; e[2]=-ps1c2;
            e[3]=-t_cs_c+ps1s3; e[4]=pc2c3; e[5]=t_ss_c+pc1s3;
            e[6]=t_cs_s+ps1c3; e[7]=-pc2s3; e[8]=-t_ss_s+pc1c3; end
         SEQ_YZY: begin e[0]=t_cc_c-ps1s3; e[1]=ps2c3; e[2]=-t_sc_c-pc1s3;
            e[3]=-pc1s2; e[4]=c2; e[5]=ps1s2;
            e[6]=t_cc_s+ps1c3; e[7]=ps2s3; e[8]=-t_sc_s+pc1c3; end
         SEQ_ZXY: begin e[0]=pc1c3-t_ss_s; e[1]=ps1c3+t_cs_s; e[2]=-pc2s3;
            e[3]=-ps1c2; e[4]=pc1c2; e[5]=s2;
            e[6]=pc1s3+t_ss_c; e[7]=ps1s3-t_cs_c; e[8]=pc2c3; end
         SEQ_ZXZ: begin e[0]=-t_sc_s+pc1c3; e[1]=t_cc_s+ps1c3; e[2]=ps2s3;
            e[3]=-t_sc_c-pc1s3; e[4]=t_cc_c-ps1s3; e[5]=ps2c3;
            e[6]=ps1s2; e[7]=-pc1s2; e[8]=c2; end
         SEQ_ZYZ: begin e[0]=t_cc_c-ps1s3; e[1]=t_sc_c+pc1s3; e[2]=-ps2c3;
            e[3]=-t_cc_s-ps1c3; e[4]=-t_sc_s+pc1c3; e[5]=ps2s3;
            e[6]=pc1s2; e[7]=ps1s2; e[8]=c2; end
         default: begin e[0]=o; e[4]=o; e[8]=o; badc = 1'b1; end
      endcase
   end

   // round half up and saturate to plus or minus one
   function automatic logic [FRAC_BITS+1:0] to_out(input q30_type v);
      q30_type r, lim;
      lim = q30_type'(1) <<< FRAC_BITS;
      r = (v + (q30_type'(1) <<< SH) / 2) >>> SH;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[FRAC_BITS+1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 9; k++) elem[k] <= to_out(e[k]);
         bad <= badc;
      end
   end

   assign valid_out = vld_ff[2];
endmodule

>>> design/euler_angles_to_rotation_matrix.sv
// euler angles to direction cosine matrix, fully pipelined
// pipeline: 11 register stages from input transfer to result transfer (1 entry, 7 cordic, 3 product)
// throughput: one item per cycle while the output is taken every cycle
// the whole pipeline advances when the output register is empty or taken
// synchronous active-high reset clears all valid bits; payload registers are not reset
// depends on ear_pkg, ear_stream_if, ear_cordic, ear_matrix
module euler_angles_to_rotation_matrix #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input logic clock,
   input logic reset,
   ear_stream_if.sink req,
   ear_stream_if.source rsp
);
   import ear_pkg::*;

   // input payload: {sequence_req, first, second, third}
   // output payload: {m00..m22, bad_sequence}
   logic [4:0] seq;
   logic [2:0][ANGLE_BITS-1:0] ang;
   logic advance;
   trig_type trig;
   logic [4:0] seq_c;
   logic vld_c, vld_m, bad;
   logic [8:0][FRAC_BITS+1:0] elem;

   assign seq = req.data[3*ANGLE_BITS +: 5];
   assign ang[0] = req.data[2*ANGLE_BITS +: ANGLE_BITS];
   assign ang[1] = req.data[ANGLE_BITS +: ANGLE_BITS];
   assign ang[2] = req.data[0 +: ANGLE_BITS];

   // single stall domain: the pipe moves when the last stage is free
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   ear_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock(clock), .reset(reset), .advance(advance),
      .angle(ang), .seq_in(seq), .valid_in(req.valid && advance),
      .trig(trig), .seq_out(seq_c), .valid_out(vld_c)
   );

   ear_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock(clock), .reset(reset), .advance(advance),
      .trig(trig), .seq_in(seq_c), .valid_in(vld_c),
      .elem(elem), .bad(bad), .valid_out(vld_m)
   );

   assign rsp.valid = vld_m;
   assign rsp.data = {elem[0], elem[1], elem[2], elem[3], elem[4],
                      elem[5], elem[6], elem[7], elem[8], bad};
endmodule

>>> design/ear_checker.sv
// port-level checks for the rotation matrix block, bound to the top level
// depends on euler_angles_to_rotation_matrix_defines.svh
`include "euler_angles_to_rotation_matrix_defines.svh"
module ear_checker #(
   parameter int FRAC_BITS = 14
) (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [9*(FRAC_BITS+2):0] rsp_data
);
   `EAR_ASSERT_NXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `EAR_ASSERT_IMP(ready_when_free, !rsp_valid, req_ready, "input stalled with empty output")
   `EAR_ASSERT_IMP(bad_gives_identity, rsp_valid && rsp_data[0], rsp_data[FRAC_BITS+1:1] == (1 << FRAC_BITS), "bad sequence without identity")
endmodule

bind euler_angles_to_rotation_matrix ear_checker #(.FRAC_BITS(FRAC_BITS)) u_ear_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

>>> bench/tb_euler_angles_to_rotation_matrix.sv
// testbench for the euler angle to direction cosine matrix block
// depends on ear_pkg, ear_stream_if and euler_angles_to_rotation_matrix
`timescale 1ns / 1ps
module tb_euler_angles_to_rotation_matrix;
   import ear_pkg::*;

   localparam int REQ_W = 5 + 3 * 16;
   localparam int RSP_W = 9 * 16 + 1;
   // first code past the last valid rotation sequence
   localparam logic [4:0] SEQ_BAD_LO = SEQ_ZYZ + 5'd1;
   localparam logic [4:0] SEQ_BAD_HI = 5'd31;
   localparam longint UNIT = 64'sd1 << 30;

   typedef struct packed {
      logic [8:0][15:0] elem;   // m00 in the top slot, row by row
      logic bad;
   } dcm_type;

   typedef struct {
      logic [4:0] seq;
      logic signed [15:0] ang1, ang2, ang3;
      bit known;                // expected result typed in below
      dcm_type dcm;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   ear_stream_if #(.WIDTH(REQ_W)) req_if ();
   ear_stream_if #(.WIDTH(RSP_W)) rsp_if ();

   euler_angles_to_rotation_matrix u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   // matrices still owed by the block, oldest first
   dcm_type pending_dcm[$];
   int errors = 0;
   int idle_pct = 0;         // sender idle chance per cycle
   int stall_pct = 0;        // receiver stall chance per cycle
   int hold_cycles = 0;      // long receiver hold-off request

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void angle_trig(input logic signed [15:0] ang,
                                      output longint sn, output longint cs);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) <<< 16;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      // fold the outer half turn onto the cordic range
      if (z > (64'sd1 << 30)) begin
         z -= 64'sd1 << 31;
         flip = 1'b1;
      end else if (z < -(64'sd1 << 30)) begin
         z += 64'sd1 << 31;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(atan_entry(i));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(atan_entry(i));
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      if (x > UNIT) x = UNIT;
      if (x < -UNIT) x = -UNIT;
      if (y > UNIT) y = UNIT;
      if (y < -UNIT) y = -UNIT;
      sn = y;
      cs = x;
   endfunction

   function automatic longint rprod(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint rprod3(input longint a, input longint b, input longint c);
      return rprod(rprod(a, b), c);
   endfunction

   function automatic logic [15:0] to_q14(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic dcm_type predict_dcm(input logic [4:0] seq,
                                           input logic signed [15:0] a1,
                                           input logic signed [15:0] a2,
                                           input logic signed [15:0] a3);
      longint s1, c1, s2, c2, s3, c3, o;
      longint e[9];
      dcm_type d;
      angle_trig(a1, s1, c1);
      angle_trig(a2, s2, c2);
      angle_trig(a3, s3, c3);
      o = UNIT;
      d.bad = 1'b0;
      case (seq)
         SEQ_X: e = '{o, 0, 0, 0, c1, s1, 0, -s1, c1};
         SEQ_Y: e = '{c1, 0, -s1, 0, o, 0, s1, 0, c1};
         SEQ_Z: e = '{c1, s1, 0, -s1, c1, 0, 0, 0, o};
         SEQ_XY: e = '{c2, rprod(s1, s2), -rprod(c1, s2), 0, c1, s1,
                       s2, -rprod(s1, c2), rprod(c1, c2)};
         SEQ_XZ: e = '{c2, rprod(c1, s2), rprod(s1, s2), -s2, rprod(c1, c2),
                       rprod(s1, c2), 0, -s1, c1};
         SEQ_YX: e = '{c1, 0, -s1, rprod(s1, s2), c2, rprod(c1, s2),
                       rprod(s1, c2), -s2, rprod(c1, c2)};
         SEQ_YZ: e = '{rprod(c1, c2), s2, -rprod(s1, c2), -rprod(c1, s2), c2,
                       rprod(s1, s2), s1, 0, c1};
         SEQ_ZX: e = '{c1, s1, 0, -rprod(s1, c2), rprod(c1, c2), s2,
                       rprod(s1, s2), -rprod(c1, s2), c2};
         SEQ_ZY: e = '{rprod(c1, c2), rprod(s1, c2), -s2, -s1, c1, 0,
                       rprod(c1, s2), rprod(s1, s2), c2};
         SEQ_ZYX: e = '{rprod(c1, c2), rprod(s1, c2), -s2,
            rprod3(c1, s2, s3) - rprod(s1, c3), rprod3(s1, s2, s3) + rprod(c1, c3),
            rprod(c2, s3),
            rprod3(c1, s2, c3) + rprod(s1, s3), rprod3(s1, s2, c3) - rprod(c1, s3),
            rprod(c2, c3)};
         SEQ_XYX: e = '{c2, rprod(s1, s2), -rprod(c1, s2),
            rprod(s2, s3), -rprod3(s1, c2, s3) + rprod(c1, c3),
            rprod3(c1, c2, s3) + rprod(s1, c3),
            rprod(s2, c3), -rprod3(s1, c2, c3) - rprod(c1, s3),
            rprod3(c1, c2, c3) - rprod(s1, s3)};
         SEQ_XYZ: e = '{rprod(c2, c3), rprod3(s1, s2, c3) + rprod(c1, s3),
            -rprod3(c1, s2, c3) + rprod(s1, s3),
            -rprod(c2, s3), -rprod3(s1, s2, s3) + rprod(c1, c3),
            rprod3(c1, s2, s3) + rprod(s1, c3),
            s2, -rprod(s1, c2), rprod(c1, c2)};
         SEQ_XZX: e = '{c2, rprod(c1, s2), rprod(s1, s2),
            -rprod(s2, c3), rprod3(c1, c2, c3) - rprod(s1, s3),
            rprod3(s1, c2, c3) + rprod(c1, s3),
            rprod(s2, s3), -rprod3(c1, c2, s3) - rprod(s1, c3),
            -rprod3(s1, c2, s3) + rprod(c1, c3)};
         SEQ_XZY: e = '{rprod(c2, c3), rprod3(c1, s2, c3) + rprod(s1, s3),
            rprod3(s1, s2, c3) - rprod(c1, s3),
            -s2, rprod(c1, c2), rprod(s1, c2),
            rprod(c2, s3), rprod3(c1, s2, s3) - rprod(s1, c3),
            rprod3(s1, s2, s3) + rprod(c1, c3)};
         SEQ_YXY: e = '{-rprod3(s1, c2, s3) + rprod(c1, c3), rprod(s2, s3),
            -rprod3(c1, c2, s3) - rprod(s1, c3),
            rprod(s1, s2), c2, rprod(c1, s2),
            rprod3(s1, c2, c3) + rprod(c1, s3), -rprod(s2, c3),
            rprod3(c1, c2, c3) - rprod(s1, s3)};
         SEQ_YXZ: e = '{rprod(c1, c3) + rprod3(s1, s2, s3), rprod(c2, s3),
            -rprod(s1, c3) + rprod3(c1, s2, s3),
            -rprod(c1, s3) + rprod3(s1, s2, c3), rprod(c2, c3),
            rprod(s1, s3) + rprod3(c1, s2, c3),
            rprod(s1, c2), -s2, rprod(c1, c2)};
         SEQ_YZX: e = '{rprod(c1, c2), s2, -rprod(s1, c2),
            -rprod3(c1, s2, c3) + rprod(s1, s3), rprod(c2, c3),
            rprod3(s1, s2, c3) + rprod(c1, s3),
            rprod3(c1, s2, s3) + rprod(s1, c3), -rprod(c2, s3),
            -rprod3(s1, s2, s3) + rprod(c1, c3)};
         SEQ_YZY: e = '{rprod3(c1, c2, c3) - rprod(s1, s3), rprod(s2, c3),
            -rprod3(s1, c2, c3) - rprod(c1, s3),
            -rprod(c1, s2), c2, rprod(s1, s2),
            rprod3(c1, c2, s3) + rprod(s1, c3), rprod(s2, s3),
            -rprod3(s1, c2, s3) + rprod(c1, c3)};
         SEQ_ZXY: e = '{rprod(c1, c3) - rprod3(s1, s2, s3),
            rprod(s1, c3) + rprod3(c1, s2, s3), -rprod(c2, s3),
            -rprod(s1, c2), rprod(c1, c2), s2,
            rprod(c1, s3) + rprod3(s1, s2, c3),
            rprod(s1, s3) - rprod3(c1, s2, c3), rprod(c2, c3)};
         SEQ_ZXZ: e = '{-rprod3(s1, c2, s3) + rprod(c1, c3),
            rprod3(c1, c2, s3) + rprod(s1, c3), rprod(s2, s3),
            -rprod3(s1, c2, c3) - rprod(c1, s3),
            rprod3(c1, c2, c3) - rprod(s1, s3), rprod(s2, c3),
            rprod(s1, s2), -rprod(c1, s2), c2};
         SEQ_ZYZ: e = '{rprod3(c1, c2, c3) - rprod(s1, s3),
            rprod3(s1, c2, c3) + rprod(c1, s3), -rprod(s2, c3),
            -rprod3(c1, c2, s3) - rprod(s1, c3),
            -rprod3(s1, c2, s3) + rprod(c1, c3), rprod(s2, s3),
            rprod(c1, s2), rprod(s1, s2), c2};
         default: begin
            // unknown sequence falls back to identity with the flag raised
            e = '{o, 0, 0, 0, o, 0, 0, 0, o};
            d.bad = 1'b1;
         end
      endcase
      for (int k = 0; k < 9; k++) d.elem[8 - k] = to_q14(e[k]);
      return d;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // receiver side: stalls plus the long hold-off
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each result transfer against the oldest pending matrix
   always @(posedge clock) begin
      dcm_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (pending_dcm.size() == 0) begin
            report_mismatch("result transfer with nothing pending", 1, 0);
         end else begin
            want = pending_dcm.pop_front();
            for (int k = 0; k < 9; k++)
               if (got.elem[8 - k] !== want.elem[8 - k])
                  report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                  $signed(got.elem[8 - k]), $signed(want.elem[8 - k]));
            if (got.bad !== want.bad)
               report_mismatch("bad_sequence", got.bad, want.bad);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   // one transfer on the request side; prediction pushed at acceptance
   task automatic send_item(input logic [4:0] seq, input logic signed [15:0] a1,
                            input logic signed [15:0] a2, input logic signed [15:0] a3);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {seq, a1, a2, a3};
      do @(posedge clock); while (!req_if.ready);
      pending_dcm.push_back(predict_dcm(seq, a1, a2, a3));
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      while (pending_dcm.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_angle;
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return ($urandom_range(1) != 0) ? 16'sh4000 : 16'shc000;
         4: return 16'(16'sh4000 + $signed(16'($urandom_range(8))) - 16'sd4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int count, input int idle, input int stall);
      logic [4:0] seq;
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         // mostly valid sequences, a few bad codes
         if ($urandom_range(15) == 0)
            seq = 5'($urandom_range(SEQ_BAD_HI, SEQ_BAD_LO));
         else
            seq = 5'($urandom_range(SEQ_ZYZ, SEQ_X));
         send_item(seq, pick_angle(), pick_angle(), pick_angle());
      end
   endtask

   vector_type directed[$];
   dcm_type ident;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      ident.elem = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, 16'sd16384};
      ident.bad = 1'b1;

      // bad codes carry their identity result; the rest go through the predictor
      directed.push_back('{SEQ_BAD_LO, 16'sh1234, -16'sd77, 16'sh7fff, 1'b1, ident});
      directed.push_back('{SEQ_BAD_HI, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, ident});
      directed.push_back('{5'd27, 16'shffff, 16'sh0000, 16'sh5555, 1'b1, ident});
      // single-axis: minus pi has zero sine; trailing angles ignored
      directed.push_back('{SEQ_X, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, ident});
      directed.push_back('{SEQ_Y, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, ident});
      directed.push_back('{SEQ_Z, 16'sh4000, 16'shffff, 16'shffff, 1'b0, ident});
      // two-axis: third angle ignored
      directed.push_back('{SEQ_XY, 16'shc000, 16'sh8000, 16'sh7fff, 1'b0, ident});
      directed.push_back('{SEQ_XZ, 16'sh2000, 16'sh4000, 16'sh8000, 1'b0, ident});
      directed.push_back('{SEQ_YX, 16'sh8000, 16'sh2aaa, 16'sh0000, 1'b0, ident});
      directed.push_back('{SEQ_YZ, 16'sh7fff, 16'shc000, 16'sh1234, 1'b0, ident});
      directed.push_back('{SEQ_ZX, 16'sh0001, 16'sh8000, 16'shffff, 1'b0, ident});
      directed.push_back('{SEQ_ZY, 16'shffff, 16'sh7fff, 16'sh8000, 1'b0, ident});
      // every three-axis sequence, with quarter and half turns mixed in
      directed.push_back('{SEQ_ZYX, 16'sh4000, 16'sh4000, 16'sh4000, 1'b0, ident});
      directed.push_back('{SEQ_XYX, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, ident});
      directed.push_back('{SEQ_XYZ, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, ident});
      directed.push_back('{SEQ_XZX, 16'sh1000, 16'shc000, 16'sh6000, 1'b0, ident});
      directed.push_back('{SEQ_XZY, 16'shc001, 16'sh3fff, 16'sh8001, 1'b0, ident});
      directed.push_back('{SEQ_YXY, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, ident});
      directed.push_back('{SEQ_YXZ, 16'sh2345, 16'shdcba, 16'sh5a5a, 1'b0, ident});
      directed.push_back('{SEQ_YZX, 16'sha5a5, 16'sh4000, 16'sh0001, 1'b0, ident});
      directed.push_back('{SEQ_YZY, 16'sh3fff, 16'sh4001, 16'shbfff, 1'b0, ident});
      directed.push_back('{SEQ_ZXY, 16'shffff, 16'shc000, 16'sh7fff, 1'b0, ident});
      directed.push_back('{SEQ_ZXZ, 16'sh6666, 16'sh9999, 16'sh8000, 1'b0, ident});
      directed.push_back('{SEQ_ZYZ, 16'sh8000, 16'sh4000, 16'shc000, 1'b0, ident});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_item(directed[i].seq, directed[i].ang1, directed[i].ang2, directed[i].ang3);
         // typed-in result must agree with the predictor's own entry
         if (directed[i].known && pending_dcm[$] !== directed[i].dcm)
            report_mismatch($sformatf("directed row %0d prediction", i), 0, 1);
      end
      drain();

      random_phase(300, 0, 0);
      drain();
      random_phase(290, 72, 0);
      random_phase(290, 0, 72);
      random_phase(290, 35, 35);
      // long hold-off: the sender keeps offering until the pipeline backs up
      hold_cycles = 150;
      random_phase(280, 0, 0);
      drain();

      repeat (30) @(posedge clock);
      if (errors == 0 && pending_dcm.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
